>>> design/cau_pkg.sv
// shared types, codes and constants of the complex arithmetic unit
`timescale 1ns / 1ps

package cau_pkg;

  // operand and result word width
  localparam int DATA_W = 32;
  // quotient bits kept by the divider before saturation
  localparam int QUO_W = 33;
  // degrees in a half turn
  localparam int DEG_SCALE = 180;
  // magnitude width of the degree value out of the cordic
  localparam int DEG_W = 40;

  // operation codes carried in tuser
  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_MUL   = 3'd2,
    MODE_DIV   = 3'd3,
    MODE_MAG   = 3'd4,
    MODE_ANGLE = 3'd5,
    MODE_EQUAL = 3'd6
  } mode_t;

  // status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DIV0 = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  // arctangent of 2^-i in binary angle units, 2^31 units per half turn
  localparam logic [31:0] ATAN_UNITS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // saturated word and its overflow flag
  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ovf;
  } sat_t;

  // results of the short paths, carried to the output stage
  typedef struct packed {
    mode_t             mode;
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic              eq;
    logic              ovf;
    logic              dz;
  } fast_t;

  // one divider result
  typedef struct packed {
    logic             neg;
    logic             big;
    logic [QUO_W-1:0] quo;
  } div_res_t;

endpackage

>>> design/cau_delay.sv
// enabled shift line that aligns a payload with the longest path
`timescale 1ns / 1ps

module cau_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  generate
    if (DEPTH == 0) begin : g_none
      assign dout = din;
    end else begin : g_line
      logic [WIDTH-1:0] tap_r [DEPTH];

      // shift one tap per enabled cycle
      always_ff @(posedge clk) begin
        if (en) begin
          tap_r[0] <= din;
          for (int k = 1; k < DEPTH; k++) begin
            tap_r[k] <= tap_r[k-1];
          end
        end
      end

      assign dout = tap_r[DEPTH-1];
    end
  endgenerate

endmodule

>>> design/cau_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module cau_div import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic             in_neg,
  input  logic [63:0]      in_num,
  input  logic [63:0]      in_den,
  output logic             out_neg,
  output logic             out_big,
  output logic [QUO_W-1:0] out_quo
);

  localparam int NW = 64 + FRAC_BITS;

  logic [NW-1:0] dividend;
  logic [63:0]   high;

  logic [63:0]      rem_r [QUO_W];
  logic [QUO_W-1:0] low_r [QUO_W];
  logic [63:0]      den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W+1];
  logic             neg_r [QUO_W+1];
  logic             big_r [QUO_W+1];

  logic [64:0] trial [QUO_W];
  logic [64:0] diff  [QUO_W];
  logic        take  [QUO_W];

  // numerator scaled by the fraction bits; the part above the quotient
  // window decides overflow
  assign dividend = {in_num, {FRAC_BITS{1'b0}}};
  assign high     = 64'(dividend[NW-1:QUO_W]);

  // trial subtraction of each stage
  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      trial[k] = {rem_r[k], low_r[k][QUO_W-1]};
      diff[k]  = trial[k] - {1'b0, den_r[k]};
      take[k]  = trial[k] >= {1'b0, den_r[k]};
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= high;
      low_r[0] <= dividend[QUO_W-1:0];
      den_r[0] <= in_den;
      quo_r[0] <= '0;
      neg_r[0] <= in_neg;
      big_r[0] <= high >= in_den;
      for (int k = 0; k < QUO_W; k++) begin
        if (k < QUO_W - 1) begin
          rem_r[k+1] <= take[k] ? diff[k][63:0] : trial[k][63:0];
          low_r[k+1] <= low_r[k] << 1;
          den_r[k+1] <= den_r[k];
        end
        quo_r[k+1] <= {quo_r[k][QUO_W-2:0], take[k]};
        neg_r[k+1] <= neg_r[k];
        big_r[k+1] <= big_r[k];
      end
    end
  end

  assign out_neg = neg_r[QUO_W];
  assign out_big = big_r[QUO_W];
  assign out_quo = quo_r[QUO_W];

endmodule

>>> design/cau_sqrt.sv
// pipelined integer square root, two radicand bits per stage
`timescale 1ns / 1ps

module cau_sqrt import cau_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [63:0]       in_n,
  output logic [DATA_W-1:0] out_root
);

  localparam int STEPS = 32;

  logic [63:0] n_r   [STEPS-1];
  logic [63:0] res_r [STEPS];

  logic [63:0] cur_n   [STEPS];
  logic [63:0] cur_res [STEPS];
  logic [63:0] sum     [STEPS];
  logic        take    [STEPS];

  // per stage compare of the remainder against the trial root
  always_comb begin
    cur_n[0]   = in_n;
    cur_res[0] = '0;
    for (int k = 1; k < STEPS; k++) begin
      cur_n[k]   = n_r[k-1];
      cur_res[k] = res_r[k-1];
    end
    for (int k = 0; k < STEPS; k++) begin
      sum[k]  = cur_res[k] + (64'd1 << (62 - 2 * k));
      take[k] = cur_n[k] >= sum[k];
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STEPS; k++) begin
        res_r[k] <= take[k] ? (cur_res[k] >> 1) + (64'd1 << (62 - 2 * k))
                            : cur_res[k] >> 1;
        if (k < STEPS - 1) begin
          n_r[k] <= take[k] ? cur_n[k] - sum[k] : cur_n[k];
        end
      end
    end
  end

  assign out_root = res_r[STEPS-1][DATA_W-1:0];

endmodule

>>> design/cau_cordic.sv
// pipelined vectoring cordic giving the angle of a in degrees
`timescale 1ns / 1ps

module cau_cordic import cau_pkg::*; #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] in_x,
  input  logic signed [DATA_W-1:0] in_y,
  output logic                     out_neg,
  output logic [DEG_W-1:0]         out_mag
);

  localparam int XW    = 36;
  localparam int ZW    = 34;
  localparam int MW    = 33;
  localparam int NORM  = 5;
  localparam int S     = CORDIC_STAGES;

  localparam logic signed [ZW-1:0] HALF_TURN    = 34'sh080000000;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sh040000000;

  // entry stage
  logic signed [XW-1:0] x0_r, y0_r;
  logic signed [ZW-1:0] z0_r, zs0_r;
  logic [MW-1:0]        m0_r;
  logic                 spec0_r;

  // normalization stages
  logic signed [XW-1:0] nx_r [NORM];
  logic signed [XW-1:0] ny_r [NORM];
  logic signed [ZW-1:0] nz_r [NORM];
  logic signed [ZW-1:0] nzs_r [NORM];
  logic                 nspec_r [NORM];
  logic [MW-1:0]        nm_r [NORM-1];

  // rotation stages
  logic signed [XW-1:0] cx_r [S-1];
  logic signed [XW-1:0] cy_r [S-1];
  logic signed [ZW-1:0] cz_r [S];
  logic signed [ZW-1:0] czs_r [S];
  logic                 cspec_r [S];

  // output stages
  logic                 neg_r;
  logic [DATA_W-1:0]    mag_r;
  logic                 out_neg_r;
  logic [DEG_W-1:0]     out_mag_r;

  logic signed [XW-1:0] xe, ye;
  logic [MW-1:0]        ax, ay;
  logic [MW-1:0]        pm [NORM];
  logic signed [XW-1:0] px [NORM];
  logic signed [XW-1:0] py [NORM];
  logic                 shl [NORM];
  logic signed [XW-1:0] rx [S];
  logic signed [XW-1:0] ry [S];
  logic signed [ZW-1:0] rz [S];
  logic signed [ZW-1:0] zc;
  logic [DEG_W-1:0]     prod;

  assign xe = XW'(in_x);
  assign ye = XW'(in_y);
  assign ax = in_x[DATA_W-1] ? MW'(-xe) : MW'(xe);
  assign ay = in_y[DATA_W-1] ? MW'(-ye) : MW'(ye);

  // inputs to the normalization and rotation stages
  always_comb begin
    pm[0] = m0_r;
    px[0] = x0_r;
    py[0] = y0_r;
    for (int j = 1; j < NORM; j++) begin
      pm[j] = nm_r[j-1];
      px[j] = nx_r[j-1];
      py[j] = ny_r[j-1];
    end
    for (int j = 0; j < NORM; j++) begin
      shl[j] = pm[j] < (MW'(1) << (30 - (16 >> j)));
    end
    rx[0] = nx_r[NORM-1];
    ry[0] = ny_r[NORM-1];
    rz[0] = nz_r[NORM-1];
    for (int k = 1; k < S; k++) begin
      rx[k] = cx_r[k-1];
      ry[k] = cy_r[k-1];
      rz[k] = cz_r[k-1];
    end
  end

  // clamp the final angle to a half turn either way
  always_comb begin
    if (cspec_r[S-1]) begin
      zc = czs_r[S-1];
    end else if (cz_r[S-1] > HALF_TURN) begin
      zc = HALF_TURN;
    end else if (cz_r[S-1] < -HALF_TURN) begin
      zc = -HALF_TURN;
    end else begin
      zc = cz_r[S-1];
    end
  end

  assign prod = DEG_W'(mag_r) * DEG_W'(DEG_SCALE);

  // entry stage: axis cases, left half plane folded over
  always_ff @(posedge clk) begin
    if (en) begin
      m0_r <= ax | ay;
      if (in_y == '0) begin
        spec0_r <= 1'b1;
        zs0_r   <= in_x[DATA_W-1] ? HALF_TURN : '0;
      end else if (in_x == '0) begin
        spec0_r <= 1'b1;
        zs0_r   <= in_y[DATA_W-1] ? -QUARTER_TURN : QUARTER_TURN;
      end else begin
        spec0_r <= 1'b0;
        zs0_r   <= '0;
      end
      if (in_x[DATA_W-1]) begin
        z0_r <= in_y[DATA_W-1] ? -HALF_TURN : HALF_TURN;
        x0_r <= -xe;
        y0_r <= -ye;
      end else begin
        z0_r <= '0;
        x0_r <= xe;
        y0_r <= ye;
      end
    end
  end

  // normalization: shift by 16, 8, 4, 2, 1 while the larger part stays small
  always_ff @(posedge clk) begin
    if (en) begin
      nz_r[0]    <= z0_r;
      nzs_r[0]   <= zs0_r;
      nspec_r[0] <= spec0_r;
      for (int j = 1; j < NORM; j++) begin
        nz_r[j]    <= nz_r[j-1];
        nzs_r[j]   <= nzs_r[j-1];
        nspec_r[j] <= nspec_r[j-1];
      end
      for (int j = 0; j < NORM; j++) begin
        nx_r[j] <= shl[j] ? px[j] <<< (16 >> j) : px[j];
        ny_r[j] <= shl[j] ? py[j] <<< (16 >> j) : py[j];
        if (j < NORM - 1) begin
          nm_r[j] <= shl[j] ? pm[j] << (16 >> j) : pm[j];
        end
      end
    end
  end

  // rotation stages toward the positive real axis
  always_ff @(posedge clk) begin
    if (en) begin
      cspec_r[0] <= nspec_r[NORM-1];
      czs_r[0]   <= nzs_r[NORM-1];
      for (int k = 1; k < S; k++) begin
        cspec_r[k] <= cspec_r[k-1];
        czs_r[k]   <= czs_r[k-1];
      end
      for (int k = 0; k < S; k++) begin
        if (!ry[k][XW-1]) begin
          cz_r[k] <= rz[k] + ZW'(ATAN_UNITS[k]);
          if (k < S - 1) begin
            cx_r[k] <= rx[k] + (ry[k] >>> k);
            cy_r[k] <= ry[k] - (rx[k] >>> k);
          end
        end else begin
          cz_r[k] <= rz[k] - ZW'(ATAN_UNITS[k]);
          if (k < S - 1) begin
            cx_r[k] <= rx[k] - (ry[k] >>> k);
            cy_r[k] <= ry[k] + (rx[k] >>> k);
          end
        end
      end
    end
  end

  // sign and magnitude, then scale to degrees
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r     <= zc[ZW-1];
      mag_r     <= zc[ZW-1] ? DATA_W'(-zc) : DATA_W'(zc);
      out_neg_r <= neg_r;
      out_mag_r <= prod >> (31 - FRAC_BITS);
    end
  end

  assign out_neg = out_neg_r;
  assign out_mag = out_mag_r;

endmodule

>>> design/complex_arithmetic_unit.sv
// top level of the complex arithmetic unit
//
// Slave stream in_*: one transaction per operation. in_tuser carries the
// mode, in_tdata the operands a and b in signed Q16.16. Master stream out_*:
// one transaction per accepted input, in the same order, with the real and
// imaginary result in out_tdata and the equal flag and status in out_tuser.
// The pipeline takes one transaction every cycle while in_tready is high;
// its length is set by the 33 quotient-bit stages of the divider plus its
// range check, or by the cordic path when that is longer. The multiplier
// stage forms all six partial products at once, so every mode flows
// through the same stages.
// Reset clears the valid bits of every stage and of the output side;
// payload registers are left as they are.
// When out_tready is low a skid register catches the next result; once it is
// full in_tready drops and the whole pipeline holds, so a stall drops or
// repeats nothing.
`timescale 1ns / 1ps

module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // a_re, a_im, b_re, b_im
  input  logic [2:0]   in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // res_re, res_im
  output logic [2:0]   out_tuser   // is_equal, status
);

  localparam int DIV_LAT  = QUO_W + 1;
  localparam int SQRT_LAT = 32;
  localparam int COR_LAT  = CORDIC_STAGES + 8;
  localparam int T_DIV    = 3 + DIV_LAT;
  localparam int T_SQRT   = 3 + SQRT_LAT;
  localparam int T_COR    = 1 + COR_LAT;
  localparam int P        = (T_DIV > T_COR) ? T_DIV : T_COR;
  localparam int FAST_W   = $bits(fast_t);
  localparam int DRES_W   = $bits(div_res_t);
  localparam int COR_W    = DEG_W + 1;

  function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag);
    sat_t r;
    if (!neg && mag > 64'h7FFF_FFFF) begin
      r.val = 32'h7FFF_FFFF;
      r.ovf = 1'b1;
    end else if (neg && mag > 64'h8000_0000) begin
      r.val = 32'h8000_0000;
      r.ovf = 1'b1;
    end else begin
      r.val = neg ? -mag[DATA_W-1:0] : mag[DATA_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  logic pipe_en, accept;
  logic [P-1:0] vld_r;

  logic signed [DATA_W-1:0] ar, ai, br, bi;

  // stage a
  mode_t                    mode_a_r;
  logic signed [DATA_W-1:0] ar_a_r, ai_a_r;
  logic signed [63:0]       p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_s0_r, p_s1_r;
  logic signed [32:0]       s_re_r, s_im_r;
  logic                     eq_a_r;
  logic signed [DATA_W-1:0] sq0, sq1;

  // stage b
  mode_t              mode_b_r;
  logic [DATA_W-1:0]  as_re_b_r, as_im_b_r;
  logic               as_ovf_b_r, eq_b_r;
  logic signed [64:0] mre_b_r, mim_b_r, nre_b_r, nim_b_r;
  logic [63:0]        den_b_r;

  // stage c
  fast_t       fast_c_r;
  logic        dneg_re_r, dneg_im_r;
  logic [63:0] dmag_re_r, dmag_im_r, den_c_r;

  logic [63:0] mmag_re, mmag_im;
  sat_t        msat_re, msat_im;

  // unit outputs and aligned copies
  div_res_t          dre, dim, dre_p, dim_p;
  logic [DATA_W-1:0] root, root_p;
  logic              cneg;
  logic [DEG_W-1:0]  cmag;
  logic [COR_W-1:0]  cor_p;
  logic [FAST_W-1:0] fast_p;
  fast_t             fp;

  // output stage
  logic [DATA_W-1:0] res_re, res_im;
  logic              res_eq;
  logic [1:0]        res_st;
  sat_t              t_re, t_im;
  logic              out_vld_r, skid_vld_r;
  logic [63:0]       out_data_r, skid_data_r;
  logic [2:0]        out_user_r, skid_user_r;

  assign pipe_en   = !skid_vld_r;
  assign in_tready = pipe_en;
  assign accept    = in_tvalid && pipe_en;

  assign ar = in_tdata[31:0];
  assign ai = in_tdata[63:32];
  assign br = in_tdata[95:64];
  assign bi = in_tdata[127:96];

  // squares of a for magnitude, of b for the divisor
  assign sq0 = (mode_t'(in_tuser) == MODE_MAG) ? ar : br;
  assign sq1 = (mode_t'(in_tuser) == MODE_MAG) ? ai : bi;

  // valid bits of every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[P-2:0], accept};
    end
  end

  // stage a: products, sums and equality
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mode_a_r <= mode_t'(in_tuser);
      ar_a_r   <= ar;
      ai_a_r   <= ai;
      p_rr_r   <= ar * br;
      p_ii_r   <= ai * bi;
      p_ri_r   <= ar * bi;
      p_ir_r   <= ai * br;
      p_s0_r   <= sq0 * sq0;
      p_s1_r   <= sq1 * sq1;
      if (mode_t'(in_tuser) == MODE_SUB) begin
        s_re_r <= 33'(ar) - 33'(br);
        s_im_r <= 33'(ai) - 33'(bi);
      end else begin
        s_re_r <= 33'(ar) + 33'(br);
        s_im_r <= 33'(ai) + 33'(bi);
      end
      eq_a_r <= (ar == br) && (ai == bi);
    end
  end

  // stage b: wide sums, add and subtract saturation
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mode_b_r   <= mode_a_r;
      eq_b_r     <= eq_a_r;
      as_re_b_r  <= (s_re_r[32] != s_re_r[31]) ? (s_re_r[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                              : s_re_r[31:0];
      as_im_b_r  <= (s_im_r[32] != s_im_r[31]) ? (s_im_r[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                              : s_im_r[31:0];
      as_ovf_b_r <= (s_re_r[32] != s_re_r[31]) || (s_im_r[32] != s_im_r[31]);
      mre_b_r    <= 65'(p_rr_r) - 65'(p_ii_r);
      mim_b_r    <= 65'(p_ri_r) + 65'(p_ir_r);
      nre_b_r    <= 65'(p_rr_r) + 65'(p_ii_r);
      nim_b_r    <= 65'(p_ir_r) - 65'(p_ri_r);
      den_b_r    <= 64'(p_s0_r) + 64'(p_s1_r);
    end
  end

  // product magnitudes truncated toward zero
  assign mmag_re = mre_b_r[64] ? 64'(-mre_b_r) : mre_b_r[63:0];
  assign mmag_im = mim_b_r[64] ? 64'(-mim_b_r) : mim_b_r[63:0];
  assign msat_re = sat_mag(mre_b_r[64], mmag_re >> FRAC_BITS);
  assign msat_im = sat_mag(mim_b_r[64], mmag_im >> FRAC_BITS);

  // stage c: multiply results, divider operands
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      fast_c_r.mode <= mode_b_r;
      fast_c_r.eq   <= eq_b_r;
      fast_c_r.dz   <= den_b_r == '0;
      if (mode_b_r == MODE_MUL) begin
        fast_c_r.re  <= msat_re.val;
        fast_c_r.im  <= msat_im.val;
        fast_c_r.ovf <= msat_re.ovf || msat_im.ovf;
      end else begin
        fast_c_r.re  <= as_re_b_r;
        fast_c_r.im  <= as_im_b_r;
        fast_c_r.ovf <= as_ovf_b_r;
      end
      dneg_re_r <= nre_b_r[64];
      dneg_im_r <= nim_b_r[64];
      dmag_re_r <= nre_b_r[64] ? 64'(-nre_b_r) : nre_b_r[63:0];
      dmag_im_r <= nim_b_r[64] ? 64'(-nim_b_r) : nim_b_r[63:0];
      den_c_r   <= den_b_r;
    end
  end

  // real part quotient
  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
    .clk     (clk),
    .en      (pipe_en),
    .in_neg  (dneg_re_r),
    .in_num  (dmag_re_r),
    .in_den  (den_c_r),
    .out_neg (dre.neg),
    .out_big (dre.big),
    .out_quo (dre.quo)
  );

  // imaginary part quotient
  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
    .clk     (clk),
    .en      (pipe_en),
    .in_neg  (dneg_im_r),
    .in_num  (dmag_im_r),
    .in_den  (den_c_r),
    .out_neg (dim.neg),
    .out_big (dim.big),
    .out_quo (dim.quo)
  );

  // magnitude root
  cau_sqrt u_sqrt (
    .clk      (clk),
    .en       (pipe_en),
    .in_n     (den_c_r),
    .out_root (root)
  );

  // angle of a
  cau_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk     (clk),
    .en      (pipe_en),
    .in_x    (ar_a_r),
    .in_y    (ai_a_r),
    .out_neg (cneg),
    .out_mag (cmag)
  );

  // align every path to the output stage
  cau_delay #(.WIDTH(FAST_W), .DEPTH(P - 3)) u_dly_fast (
    .clk (clk), .en (pipe_en), .din (fast_c_r), .dout (fast_p)
  );

  cau_delay #(.WIDTH(2 * DRES_W), .DEPTH(P - T_DIV)) u_dly_div (
    .clk (clk), .en (pipe_en), .din ({dre, dim}), .dout ({dre_p, dim_p})
  );

  cau_delay #(.WIDTH(DATA_W), .DEPTH(P - T_SQRT)) u_dly_sqrt (
    .clk (clk), .en (pipe_en), .din (root), .dout (root_p)
  );

  cau_delay #(.WIDTH(COR_W), .DEPTH(P - T_COR)) u_dly_cor (
    .clk (clk), .en (pipe_en), .din ({cneg, cmag}), .dout (cor_p)
  );

  assign fp = fast_t'(fast_p);

  // result select and final saturation
  always_comb begin
    res_re = '0;
    res_im = '0;
    res_eq = 1'b0;
    res_st = STATUS_OK;
    t_re   = '0;
    t_im   = '0;
    case (fp.mode)
      MODE_ADD, MODE_SUB, MODE_MUL: begin
        res_re = fp.re;
        res_im = fp.im;
        res_st = fp.ovf ? STATUS_SAT : STATUS_OK;
      end
      MODE_DIV: begin
        if (fp.dz) begin
          res_st = STATUS_DIV0;
        end else begin
          t_re   = sat_mag(dre_p.neg, dre_p.big ? '1 : 64'(dre_p.quo));
          t_im   = sat_mag(dim_p.neg, dim_p.big ? '1 : 64'(dim_p.quo));
          res_re = t_re.val;
          res_im = t_im.val;
          res_st = (t_re.ovf || t_im.ovf) ? STATUS_SAT : STATUS_OK;
        end
      end
      MODE_MAG: begin
        t_re   = sat_mag(1'b0, 64'(root_p));
        res_re = t_re.val;
        res_st = t_re.ovf ? STATUS_SAT : STATUS_OK;
      end
      MODE_ANGLE: begin
        t_re   = sat_mag(cor_p[DEG_W], 64'(cor_p[DEG_W-1:0]));
        res_re = t_re.val;
        res_st = t_re.ovf ? STATUS_SAT : STATUS_OK;
      end
      MODE_EQUAL: begin
        res_eq = fp.eq;
      end
      default: begin
        res_st = STATUS_OK;
      end
    endcase
  end

  // output register and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= vld_r[P-1];
      end
    end else if (vld_r[P-1] && !skid_vld_r) begin
      skid_vld_r <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end else begin
        out_data_r <= {res_im, res_re};
        out_user_r <= {res_st, res_eq};
      end
    end else if (!skid_vld_r) begin
      skid_data_r <= {res_im, res_re};
      skid_user_r <= {res_st, res_eq};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> tb/sv/tb_complex_arithmetic_unit.sv
// self-checking testbench for the complex arithmetic unit
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  // spare operation code with no defined function
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int FRAC = 16;
  localparam int STAGES = 24;
  localparam longint HALF_TURN = 64'sd2147483648;
  localparam int N_RANDOM = 550;
  localparam int DRAIN_CYCLES = 60;

  // one expected result transaction
  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        eq;
    logic [1:0]  st;
  } cau_result_t;

  // predicts every result from the operands and checks the output in order
  class cau_scoreboard;
    cau_result_t pending_results[$];
    int errors = 0;

    function automatic longint unsigned abs_u(longint v);
      longint unsigned u;
      u = v;
      return (v < 0) ? (64'd0 - u) : u;
    endfunction

    // clamp a sign and magnitude to the 32-bit range
    function automatic logic [31:0] clamp32(bit neg, longint unsigned mag, inout bit ovf);
      if (!neg && mag > 64'h7FFF_FFFF) begin
        ovf = 1'b1;
        return 32'h7FFF_FFFF;
      end
      if (neg && mag > 64'h8000_0000) begin
        ovf = 1'b1;
        return 32'h8000_0000;
      end
      return neg ? 32'(64'd0 - mag) : mag[31:0];
    endfunction

    // sum of two products as sign and magnitude, magnitude may reach 2^63
    function automatic void signed_sum(longint p, longint q, output bit neg,
                                       output longint unsigned mag);
      longint s;
      if (p >= 0 && q >= 0) begin
        neg = 1'b0;
        mag = abs_u(p) + abs_u(q);
      end else if (p < 0 && q < 0) begin
        neg = 1'b1;
        mag = abs_u(p) + abs_u(q);
      end else begin
        s = p + q;
        neg = s < 0;
        mag = abs_u(s);
      end
    endfunction

    // fixed-point quotient by restoring long division
    function automatic logic [31:0] quotient(bit neg, longint unsigned num,
                                             longint unsigned den, inout bit ovf);
      longint unsigned q, r;
      q = num / den;
      r = num % den;
      if (q > 64'h1_0000_0000) return clamp32(neg, q, ovf);
      repeat (FRAC) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 64'd1;
        end
      end
      return clamp32(neg, q, ovf);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // vectoring cordic, binary angle units with 2^31 per half turn
    function automatic longint phase_units(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      if (y == 0) return (x < 0) ? HALF_TURN : 0;
      if (x == 0) return (y > 0) ? HALF_TURN / 2 : -HALF_TURN / 2;
      if (x < 0) begin
        z = (y > 0) ? HALF_TURN : -HALF_TURN;
        x = -x;
        y = -y;
      end
      while (abs_u(x) < (64'd1 << 29) && abs_u(y) < (64'd1 << 29)) begin
        x = x * 2;
        y = y * 2;
      end
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + longint'(ATAN_UNITS[i]);
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - longint'(ATAN_UNITS[i]);
        end
      end
      if (z > HALF_TURN) z = HALF_TURN;
      if (z < -HALF_TURN) z = -HALF_TURN;
      return z;
    endfunction

    function automatic cau_result_t compute(logic [2:0] mode, logic [31:0] a_re,
                                            logic [31:0] a_im, logic [31:0] b_re,
                                            logic [31:0] b_im);
      cau_result_t r;
      longint ar, ai, br, bi, s, z;
      longint unsigned m, den;
      bit ovf, neg;
      ar = longint'($signed(a_re));
      ai = longint'($signed(a_im));
      br = longint'($signed(b_re));
      bi = longint'($signed(b_im));
      r = '{re: '0, im: '0, eq: 1'b0, st: STATUS_OK};
      ovf = 1'b0;
      case (mode)
        MODE_ADD, MODE_SUB: begin
          s = (mode == MODE_ADD) ? ar + br : ar - br;
          r.re = clamp32(s < 0, abs_u(s), ovf);
          s = (mode == MODE_ADD) ? ai + bi : ai - bi;
          r.im = clamp32(s < 0, abs_u(s), ovf);
        end
        MODE_MUL: begin
          signed_sum(ar * br, -(ai * bi), neg, m);
          r.re = clamp32(neg, m >> FRAC, ovf);
          signed_sum(ar * bi, ai * br, neg, m);
          r.im = clamp32(neg, m >> FRAC, ovf);
        end
        MODE_DIV: begin
          den = longint'(br * br) + longint'(bi * bi);
          if (den == 0) begin
            r.st = STATUS_DIV0;
          end else begin
            signed_sum(ar * br, ai * bi, neg, m);
            r.re = quotient(neg, m, den, ovf);
            signed_sum(ai * br, -(ar * bi), neg, m);
            r.im = quotient(neg, m, den, ovf);
          end
        end
        MODE_MAG: begin
          m = int_sqrt(longint'(ar * ar) + longint'(ai * ai));
          r.re = clamp32(1'b0, m, ovf);
        end
        MODE_ANGLE: begin
          z = phase_units(ar, ai);
          m = (abs_u(z) * 64'd180) >> (31 - FRAC);
          r.re = clamp32(z < 0, m, ovf);
        end
        MODE_EQUAL: r.eq = (ar == br && ai == bi);
        default: ;
      endcase
      if (ovf) r.st = STATUS_SAT;
      return r;
    endfunction

    function void note_input(logic [2:0] mode, logic [31:0] a_re, logic [31:0] a_im,
                             logic [31:0] b_re, logic [31:0] b_im);
      pending_results.push_back(compute(mode, a_re, a_im, b_re, b_im));
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endfunction

    function void check_result(logic [63:0] data, logic [2:0] user);
      cau_result_t e;
      if (pending_results.size() == 0) begin
        report("unexpected transaction", {29'd0, user}, 32'd0);
        return;
      end
      e = pending_results.pop_front();
      if (data[31:0] !== e.re) report("res_re", data[31:0], e.re);
      if (data[63:32] !== e.im) report("res_im", data[63:32], e.im);
      if (user[0] !== e.eq) report("is_equal", {31'd0, user[0]}, {31'd0, e.eq});
      if (user[2:1] !== e.st) report("status", {30'd0, user[2:1]}, {30'd0, e.st});
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [2:0]   out_tuser;

  cau_scoreboard results_sb = new();
  int hold_off_cycles = 0;

  complex_arithmetic_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) results_sb.check_result(out_tdata, out_tuser);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 9) < 6) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 50)
                                                  : $urandom_range(0, 2);
      end
    end
  end

  // one input transaction followed by an optional idle gap
  task automatic send_op(logic [2:0] mode, logic [31:0] a_re, logic [31:0] a_im,
                         logic [31:0] b_re, logic [31:0] b_im, bit burst);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {b_im, b_re, a_im, a_re};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    results_sb.note_input(mode, a_re, a_im, b_re, b_im);
    if (burst) gap = 0;
    else if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 40);
    else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    else gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // operand word: fully random, small near zero, a small whole number, or an edge value
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh3FFFF);
      4: begin
        case ($urandom_range(0, 6))
          0: return 32'h0;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'h0001_0000;
          4: return 32'hFFFF_0000;
          5: return 32'h1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return 32'($signed($urandom_range(0, 32'h1FF)) - 32'sd256) << 16;
    endcase
  endfunction

  initial begin
    logic [2:0]  mode;
    logic [31:0] ar, ai, br, bi;
    bit          burst;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every mode and the corner cases
    send_op(MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_op(MODE_ADD, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_4000, 32'h0002_0000, 0);
    send_op(MODE_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 0);
    send_op(MODE_SUB, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0, 0);
    send_op(MODE_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0004_0000, 0);
    send_op(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_op(MODE_MUL, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0, 0);
    send_op(MODE_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 0);
    send_op(MODE_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 0);
    send_op(MODE_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0, 0);
    send_op(MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_op(MODE_MAG, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 0);
    send_op(MODE_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 0);
    send_op(MODE_ANGLE, 32'h0, 32'h0, 32'h0, 32'h0, 0);
    send_op(MODE_ANGLE, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 0);
    send_op(MODE_ANGLE, 32'h0, 32'h0005_0000, 32'h0, 32'h0, 0);
    send_op(MODE_ANGLE, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 0);
    send_op(MODE_ANGLE, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 0);
    send_op(MODE_ANGLE, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 0);
    send_op(MODE_ANGLE, 32'hFFFF_0000, 32'h0000_0001, 32'h0, 32'h0, 0);
    send_op(MODE_ANGLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 0);
    send_op(MODE_EQUAL, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000, 0);
    send_op(MODE_EQUAL, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0001, 0);
    send_op(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

    // random operations, one long receiver hold-off with the sender bursting
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200) hold_off_cycles = 300;
      burst = (n >= 200 && n < 280) || (n >= 400 && n < 440);
      mode = ($urandom_range(0, 29) == 0) ? MODE_UNUSED : 3'($urandom_range(0, 6));
      ar = pick_word();
      ai = ($urandom_range(0, 5) == 0) ? 32'h0 : pick_word();
      br = pick_word();
      bi = ($urandom_range(0, 5) == 0) ? 32'h0 : pick_word();
      if (mode == MODE_EQUAL && $urandom_range(0, 1)) begin
        br = ar;
        bi = $urandom_range(0, 1) ? ai : ai ^ (32'h1 << $urandom_range(0, 31));
      end
      if (mode == MODE_DIV && $urandom_range(0, 9) == 0) begin
        br = 32'h0;
        bi = 32'h0;
      end
      send_op(mode, ar, ai, br, bi, burst);
    end
    in_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    while (results_sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
